// ===== src/triangle_tangent_basis_unit_macros.svh =====
// assertion macros shared by the triangle tangent basis rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef TRIANGLE_TANGENT_BASIS_UNIT_MACROS_SVH
`define TRIANGLE_TANGENT_BASIS_UNIT_MACROS_SVH

// same-cycle implication
`define TTB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ttb_pkg.sv =====
// package for the triangle tangent basis unit: field widths and payload types
// no dependencies
`timescale 1ns / 1ps

package ttb_pkg;

	localparam int POS_W  = 32;
	localparam int UV_W   = 24;
	localparam int OUT_W  = 16;
	localparam int E_W    = POS_W + 1;
	localparam int D_W    = UV_W + 1;
	// magnitude bits kept before the length is taken
	localparam int NB     = 30;
	localparam int MB     = (D_W > NB) ? D_W : NB;
	localparam int SQ_W   = 2 * NB + 2;
	localparam int PROD_W = E_W + D_W + 1;
	localparam int ACC_W  = (PROD_W > SQ_W) ? PROD_W : SQ_W;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [UV_W-1:0]  tex_u;
		logic signed [UV_W-1:0]  tex_v;
	} corner_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] tangent_x;
		logic signed [OUT_W-1:0] tangent_y;
		logic signed [OUT_W-1:0] tangent_z;
		logic signed [OUT_W-1:0] bitangent_x;
		logic signed [OUT_W-1:0] bitangent_y;
		logic signed [OUT_W-1:0] bitangent_z;
		logic                    degenerate;
	} basis_t;

	// edge vectors and uv deltas of one triangle, two's complement
	typedef struct packed {
		logic [2:0][E_W-1:0] e0;
		logic [2:0][E_W-1:0] e1;
		logic [D_W-1:0]      du0;
		logic [D_W-1:0]      dv0;
		logic [D_W-1:0]      du1;
		logic [D_W-1:0]      dv1;
	} delta_t;

endpackage

// ===== src/ttb_engine.sv =====
// bit-serial arithmetic engine: products, vector length and unit components
// depends on ttb_pkg
`timescale 1ns / 1ps

module ttb_engine #(
	parameter int UNIT_FRAC_BITS = 14
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ttb_pkg::delta_t delta,
	output logic            done,
	output ttb_pkg::basis_t result
);
	import ttb_pkg::*;

	localparam int F      = UNIT_FRAC_BITS;
	localparam int QB     = F + 1;
	localparam int NW     = NB + F + 1;
	localparam int LEN_W  = NB + 1;
	localparam int QX_W   = (F + 2 > OUT_W) ? F + 2 : OUT_W;
	localparam int SQ_STEPS = SQ_W / 2;
	localparam int MAXC_A = (MB > SQ_STEPS) ? MB : SQ_STEPS;
	localparam int MAXC   = (MAXC_A > QB) ? MAXC_A : QB;
	localparam int CNT_W  = $clog2(MAXC);

	localparam logic [CNT_W-1:0] RUN_LAST  = CNT_W'(MB - 1);
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQ_STEPS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QB - 1);
	localparam logic [SQ_W-1:0]  SQRT_TOP  = {2'b01, {(SQ_W-2){1'b0}}};
	localparam logic [3:0]       OP_FIRST  = 4'd0;
	localparam logic [3:0]       OP_DET    = 4'd1;
	localparam logic [3:0]       OP_LAST   = 4'd13;
	localparam basis_t           DEGEN_RESULT = '{degenerate: 1'b1, default: '0};

	typedef enum logic [3:0] {
		S_IDLE, S_PROD_LD, S_RUN, S_PSTORE, S_MAG_LD, S_MAG_SH, S_SQ_LD,
		S_SQRT_LD, S_SQRT, S_DIV_LD, S_DIV_RUN, S_DIV_ST, S_DONE
	} state_t;

	function automatic logic [ACC_W-1:0] sx_e(input logic [E_W-1:0] x);
		return {{(ACC_W-E_W){x[E_W-1]}}, x};
	endfunction

	function automatic logic [ACC_W-1:0] sx_d(input logic [D_W-1:0] x);
		return {{(ACC_W-D_W){x[D_W-1]}}, x};
	endfunction

	state_t             state_q;
	logic [3:0]         op_q;
	logic [1:0]         idx_q;
	logic               vsel_q;
	logic               sq_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ACC_W-1:0]   a_q;
	logic [MB-1:0]      b_q;
	logic [ACC_W-1:0]   acc_q;
	logic               det_neg_q;
	logic [ACC_W-1:0]   tv_q [0:2];
	logic [ACC_W-1:0]   bv_q [0:2];
	logic [ACC_W-1:0]   mag_q [0:2];
	logic [SQ_W-1:0]    n_q;
	logic [SQ_W-1:0]    r_q;
	logic [SQ_W-1:0]    bit_q;
	logic [LEN_W-1:0]   rem_q;
	logic [QB-1:0]      nlo_q;
	logic [QB-1:0]      quo_q;

	logic [3:0]         k;
	logic [1:0]         c;
	logic [ACC_W-1:0]   opa;
	logic [D_W-1:0]     opb;
	logic [D_W-1:0]     bmag;
	logic               opneg;
	logic [ACC_W-1:0]   mag_or;
	logic               mag_hi;
	logic [NB-1:0]      mag_lo;
	logic [SQ_W-1:0]    st;
	logic [LEN_W-1:0]   len_w;
	logic [NW-1:0]      numer;
	logic [LEN_W:0]     dt;
	logic [LEN_W:0]     dsub;
	logic               vsgn;
	logic [QX_W-1:0]    qx;
	logic [QX_W-1:0]    sv;
	logic [OUT_W-1:0]   comp;

	// operand selection for the fourteen signed products
	always_comb begin
		k = op_q - 4'd2;
		c = k[3:2];
		if (op_q == OP_FIRST) begin
			opa = sx_d(delta.du0);
			opb = delta.dv1;
		end else if (op_q == OP_DET) begin
			opa = sx_d(delta.du1);
			opb = delta.dv0;
		end else begin
			case (k[1:0])
				2'd0: begin
					opa = sx_e(delta.e0[c]);
					opb = delta.dv1;
				end
				2'd1: begin
					opa = sx_e(delta.e1[c]);
					opb = delta.dv0;
				end
				2'd2: begin
					opa = sx_e(delta.e1[c]);
					opb = delta.du0;
				end
				default: begin
					opa = sx_e(delta.e0[c]);
					opb = delta.du1;
				end
			endcase
		end
		bmag  = opb[D_W-1] ? -opb : opb;
		// odd ops are subtracted from the running sum
		opneg = opb[D_W-1] ^ op_q[0];
	end

	assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];
	assign mag_hi = |mag_or[ACC_W-1:NB];
	assign mag_lo = mag_q[idx_q][NB-1:0];
	assign st     = r_q + bit_q;
	assign len_w  = r_q[LEN_W-1:0];
	assign numer  = (NW'(mag_lo) << F) + NW'(len_w >> 1);
	assign dt     = {rem_q, nlo_q[QB-1]};
	assign dsub   = dt - {1'b0, len_w};
	assign vsgn   = vsel_q ? bv_q[idx_q][ACC_W-1] : tv_q[idx_q][ACC_W-1];
	assign qx     = QX_W'(quo_q);
	assign sv     = (vsgn ^ det_neg_q) ? -qx : qx;
	assign comp   = sv[OUT_W-1:0];
	assign done   = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_FIRST;
			idx_q   <= '0;
			vsel_q  <= 1'b0;
			sq_q    <= 1'b0;
			result  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= OP_FIRST;
						vsel_q  <= 1'b0;
						sq_q    <= 1'b0;
						result  <= '0;
						state_q <= S_PROD_LD;
					end
				end
				S_PROD_LD: state_q <= S_RUN;
				S_RUN: begin
					if (cnt_q == RUN_LAST) begin
						if (!sq_q) begin
							state_q <= S_PSTORE;
						end else if (idx_q == 2'd2) begin
							state_q <= S_SQRT_LD;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= S_SQ_LD;
						end
					end
				end
				S_PSTORE: begin
					op_q <= op_q + 4'd1;
					if (op_q == OP_DET && acc_q == '0) begin
						result  <= DEGEN_RESULT;
						state_q <= S_DONE;
					end else if (op_q == OP_LAST) begin
						state_q <= S_MAG_LD;
					end else begin
						state_q <= S_PROD_LD;
					end
				end
				S_MAG_LD: state_q <= S_MAG_SH;
				S_MAG_SH: begin
					if (mag_or == '0) begin
						result  <= DEGEN_RESULT;
						state_q <= S_DONE;
					end else if (!mag_hi) begin
						idx_q   <= '0;
						sq_q    <= 1'b1;
						state_q <= S_SQ_LD;
					end
				end
				S_SQ_LD:   state_q <= S_RUN;
				S_SQRT_LD: state_q <= S_SQRT;
				S_SQRT: begin
					if (cnt_q == SQRT_LAST) begin
						idx_q   <= '0;
						state_q <= S_DIV_LD;
					end
				end
				S_DIV_LD: begin
					if (len_w == '0) begin
						result  <= DEGEN_RESULT;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV_RUN;
					end
				end
				S_DIV_RUN: begin
					if (cnt_q == DIV_LAST) state_q <= S_DIV_ST;
				end
				S_DIV_ST: begin
					case ({vsel_q, idx_q})
						3'b000:  result.tangent_x   <= comp;
						3'b001:  result.tangent_y   <= comp;
						3'b010:  result.tangent_z   <= comp;
						3'b100:  result.bitangent_x <= comp;
						3'b101:  result.bitangent_y <= comp;
						3'b110:  result.bitangent_z <= comp;
						default: ;
					endcase
					if (idx_q == 2'd2) begin
						if (vsel_q) begin
							state_q <= S_DONE;
						end else begin
							vsel_q  <= 1'b1;
							sq_q    <= 1'b0;
							state_q <= S_MAG_LD;
						end
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_DIV_LD;
					end
				end
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_PROD_LD: begin
				a_q   <= opneg ? -opa : opa;
				b_q   <= MB'(bmag);
				cnt_q <= '0;
				if (!op_q[0]) acc_q <= '0;
			end
			S_RUN: begin
				// shift-add, one multiplier bit per cycle
				if (b_q[0]) acc_q <= acc_q + a_q;
				a_q   <= a_q << 1;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			S_PSTORE: begin
				if (op_q == OP_DET) begin
					det_neg_q <= acc_q[ACC_W-1];
				end else if (op_q[0]) begin
					if (!k[1]) tv_q[c] <= acc_q;
					else bv_q[c] <= acc_q;
				end
			end
			S_MAG_LD: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= vsel_q ? (bv_q[i][ACC_W-1] ? -bv_q[i] : bv_q[i])
						: (tv_q[i][ACC_W-1] ? -tv_q[i] : tv_q[i]);
				end
			end
			S_MAG_SH: begin
				// truncating shift until the widest magnitude fits
				if (mag_hi) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end
			end
			S_SQ_LD: begin
				a_q   <= ACC_W'(mag_lo);
				b_q   <= MB'(mag_lo);
				cnt_q <= '0;
				if (idx_q == 2'd0) acc_q <= '0;
			end
			S_SQRT_LD: begin
				n_q   <= acc_q[SQ_W-1:0];
				r_q   <= '0;
				bit_q <= SQRT_TOP;
				cnt_q <= '0;
			end
			S_SQRT: begin
				if (n_q >= st) begin
					n_q <= n_q - st;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			S_DIV_LD: begin
				rem_q <= LEN_W'(numer >> QB);
				nlo_q <= numer[QB-1:0];
				quo_q <= '0;
				cnt_q <= '0;
			end
			S_DIV_RUN: begin
				// restoring division, one quotient bit per cycle
				if (dt >= {1'b0, len_w}) begin
					rem_q <= dsub[LEN_W-1:0];
					quo_q <= {quo_q[QB-2:0], 1'b1};
				end else begin
					rem_q <= dt[LEN_W-1:0];
					quo_q <= {quo_q[QB-2:0], 1'b0};
				end
				nlo_q <= nlo_q << 1;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			default: ;
		endcase
	end

endmodule

// ===== src/triangle_tangent_basis_unit.sv =====
// Per-triangle tangent and bitangent. Corners stream in on the corner channel;
// the first two corners of a triangle are registered as they are taken, and the
// third starts a bit-serial engine that builds the UV determinant, the tangent
// and the bitangent with one shift-add multiplier (fourteen products), then
// normalizes each vector with a 31-step square root and three 15-step
// divisions. Corners are stalled while that single serial multiplier and the
// length unit work on a triangle. One result per triangle leaves on the basis
// channel through an output register; degenerate triangles give zero vectors
// with the degenerate flag set.
// depends on ttb_pkg, ttb_engine and triangle_tangent_basis_unit_macros.svh
`timescale 1ns / 1ps
`include "triangle_tangent_basis_unit_macros.svh"

module triangle_tangent_basis_unit #(
	parameter int UNIT_FRAC_BITS = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             corner_valid,
	output logic             corner_stall,
	input  ttb_pkg::corner_t corner,
	output logic             basis_valid,
	input  logic             basis_stall,
	output ttb_pkg::basis_t  basis
);
	import ttb_pkg::*;

	logic [1:0] cnt_q;
	logic       busy_q;
	logic       start_q;
	corner_t    c0_q;
	corner_t    c1_q;
	delta_t     delta_q;
	logic       take;
	logic       eng_done;
	basis_t     eng_res;
	logic       vec_zero;

	// third corner waits while a result is still unread
	assign corner_stall = busy_q | ((cnt_q == 2'd2) & basis_valid);
	assign take         = corner_valid & ~corner_stall;

	assign vec_zero = basis.tangent_x == '0 && basis.tangent_y == '0
		&& basis.tangent_z == '0 && basis.bitangent_x == '0
		&& basis.bitangent_y == '0 && basis.bitangent_z == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			basis_valid <= 1'b0;
		end else begin
			start_q <= take && (cnt_q == 2'd2);
			if (take) begin
				if (cnt_q == 2'd2) begin
					cnt_q  <= '0;
					busy_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 2'd1;
				end
			end
			if (eng_done) begin
				busy_q      <= 1'b0;
				basis_valid <= 1'b1;
			end else if (basis_valid && !basis_stall) begin
				basis_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (cnt_q == 2'd0) c0_q <= corner;
			if (cnt_q == 2'd1) c1_q <= corner;
			if (cnt_q == 2'd2) begin
				delta_q.e0[0] <= {c1_q.pos_x[POS_W-1], c1_q.pos_x}
					- {c0_q.pos_x[POS_W-1], c0_q.pos_x};
				delta_q.e0[1] <= {c1_q.pos_y[POS_W-1], c1_q.pos_y}
					- {c0_q.pos_y[POS_W-1], c0_q.pos_y};
				delta_q.e0[2] <= {c1_q.pos_z[POS_W-1], c1_q.pos_z}
					- {c0_q.pos_z[POS_W-1], c0_q.pos_z};
				delta_q.e1[0] <= {corner.pos_x[POS_W-1], corner.pos_x}
					- {c0_q.pos_x[POS_W-1], c0_q.pos_x};
				delta_q.e1[1] <= {corner.pos_y[POS_W-1], corner.pos_y}
					- {c0_q.pos_y[POS_W-1], c0_q.pos_y};
				delta_q.e1[2] <= {corner.pos_z[POS_W-1], corner.pos_z}
					- {c0_q.pos_z[POS_W-1], c0_q.pos_z};
				delta_q.du0 <= {c1_q.tex_u[UV_W-1], c1_q.tex_u}
					- {c0_q.tex_u[UV_W-1], c0_q.tex_u};
				delta_q.dv0 <= {c1_q.tex_v[UV_W-1], c1_q.tex_v}
					- {c0_q.tex_v[UV_W-1], c0_q.tex_v};
				delta_q.du1 <= {corner.tex_u[UV_W-1], corner.tex_u}
					- {c0_q.tex_u[UV_W-1], c0_q.tex_u};
				delta_q.dv1 <= {corner.tex_v[UV_W-1], corner.tex_v}
					- {c0_q.tex_v[UV_W-1], c0_q.tex_v};
			end
		end
		if (eng_done) basis <= eng_res;
	end

	ttb_engine #(
		.UNIT_FRAC_BITS(UNIT_FRAC_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.delta  (delta_q),
		.done   (eng_done),
		.result (eng_res)
	);

	`TTB_ASSERT_IMPL(a_done_while_busy, eng_done, busy_q, "engine done with nothing in flight")
	`TTB_ASSERT_IMPL(a_start_busy, start_q, busy_q && !basis_valid, "start over a pending result")
	`TTB_ASSERT_NEXT(a_done_loads_out, eng_done, basis_valid, "finished triangle not presented")
	`TTB_ASSERT_IMPL(a_degen_zero, basis_valid && basis.degenerate, vec_zero, "degenerate nonzero")

endmodule
